[sv/playfair_encrypt_defines.svh]
// ----------------------------------------------------------------------------
// Playfair encryption assertion macros
// Clocked assertion helpers shared by the RTL files of the block.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_ENCRYPT_DEFINES_SVH
`define PLAYFAIR_ENCRYPT_DEFINES_SVH

`ifndef SYNTHESIS
// check a property at every clock edge outside reset
`define PFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// check a property at every clock edge, reset included
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PFE_ASSERT(lbl, clk, rstn, prop, msg)
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// Playfair encryption package
// Letter codes, command codes, controller states and square geometry helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

    localparam int LETTER_W = 5;
    localparam int CELLS    = 25;
    localparam int LETTERS  = 26;
    localparam int SIDE     = 5;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Q = 5'd16;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

    typedef enum logic [1:0] {
        CMD_KEY      = 2'd0,
        CMD_KEY_DONE = 2'd1,
        CMD_MSG      = 2'd2,
        CMD_END      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_POS,
        S_CELL,
        S_OUT0,
        S_OUT1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic fill;
        logic second;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic key_done;
        logic pair;
        logic fill_last;
    } t_sts;

    function automatic logic [2:0] pos_row(input logic [LETTER_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] pos_col(input logic [LETTER_W-1:0] p);
        logic [LETTER_W-1:0] base;
        base = {pos_row(p), 2'b00} + 5'(pos_row(p));
        return 3'(p - base);
    endfunction

    // advance one cell with wraparound
    function automatic logic [2:0] wrap_next(input logic [2:0] x);
        return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [LETTER_W-1:0] cell_addr(input logic [2:0] row,
                                                      input logic [2:0] col);
        return {row, 2'b00} + 5'(row) + 5'(col);
    endfunction

endpackage

`default_nettype wire

[sv/pfe_in_if.sv]
// ----------------------------------------------------------------------------
// Playfair input channel
// Valid/ready channel carrying one command word: command and letter.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [pfe_pkg::LETTER_W-1:0]   letter;

    modport source (output valid, output cmd, output letter, input ready);
    modport sink   (input valid, input cmd, input letter, output ready);
endinterface

`default_nettype wire

[sv/pfe_out_if.sv]
// ----------------------------------------------------------------------------
// Playfair output channel
// Valid/ready channel carrying one cipher letter word with its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_out_if;
    logic                           valid;
    logic                           ready;
    logic [pfe_pkg::LETTER_W-1:0]   cipher_letter;
    logic                           last;

    modport source (output valid, output cipher_letter, output last, input ready);
    modport sink   (input valid, input cipher_letter, input last, output ready);
endinterface

`default_nettype wire

[sv/pfe_datapath.sv]
// ----------------------------------------------------------------------------
// Playfair datapath
// Square and letter position memories, key fill, pair former and lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfair_encrypt_defines.svh"

module pfe_datapath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  pfe_pkg::t_ctl                 i_ctl,
    output pfe_pkg::t_sts                 o_sts,
    input  wire [1:0]                     i_in_cmd,
    input  wire [pfe_pkg::LETTER_W-1:0]   i_in_letter,
    output logic [pfe_pkg::LETTER_W-1:0]  o_cipher_letter,
    output logic                          o_last
);
    import pfe_pkg::*;

    logic [LETTER_W-1:0] mem_sq  [CELLS];
    logic [LETTER_W-1:0] mem_pos [LETTERS];
    logic                r_used  [LETTERS];

    logic [LETTER_W-1:0] r_fill_count;
    logic [LETTER_W-1:0] r_fill_idx;
    logic [LETTER_W-1:0] r_pend_letter;
    logic                r_pend_valid;
    logic [LETTER_W-1:0] r_pair_a;
    logic [LETTER_W-1:0] r_pair_b;
    logic [LETTER_W-1:0] r_pos_a;
    logic [LETTER_W-1:0] r_pos_b;
    logic [LETTER_W-1:0] r_cell_a;
    logic [LETTER_W-1:0] r_cell_b;

    t_cmd                in_cmd;
    logic                full;
    logic                v_ok;
    logic [LETTER_W-1:0] msg_v;
    logic                dup;
    logic                msg_take;
    logic                msg_pair;
    logic                end_pair;
    logic [LETTER_W-1:0] pair_b;
    logic [LETTER_W-1:0] place_v;
    logic                place_req;
    logic                place_en;
    logic [2:0]          r1, c1, r2, c2;
    logic [LETTER_W-1:0] addr_a;
    logic [LETTER_W-1:0] addr_b;

    always_comb begin
        in_cmd   = t_cmd'(i_in_cmd);
        full     = (r_fill_count == 5'(CELLS));
        v_ok     = (i_in_letter < 5'(LETTERS));
        msg_v    = (i_in_letter == LETTER_J) ? LETTER_I : i_in_letter;
        dup      = (msg_v == r_pend_letter);
        msg_take = (in_cmd == CMD_MSG) && full && v_ok;
        msg_pair = msg_take && r_pend_valid;
        end_pair = (in_cmd == CMD_END) && full && r_pend_valid;
        if (end_pair) begin
            pair_b = LETTER_X;
        end else if (dup) begin
            pair_b = (msg_v == LETTER_X) ? LETTER_Q : LETTER_X;
        end else begin
            pair_b = msg_v;
        end
        o_sts.key_done  = (in_cmd == CMD_KEY_DONE);
        o_sts.pair      = msg_pair || end_pair;
        o_sts.fill_last = (r_fill_idx == 5'(LETTERS - 1));
    end

    // at most one letter placed per cycle, either a key word or a fill sweep step
    always_comb begin
        place_v   = i_ctl.fill ? r_fill_idx : i_in_letter;
        place_req = i_ctl.fill || (i_ctl.accept && (in_cmd == CMD_KEY));
        place_en  = place_req && (place_v < 5'(LETTERS)) && (place_v != LETTER_J)
                    && !full && !r_used[place_v];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_count <= '0;
            r_fill_idx   <= '0;
            r_pend_valid <= 1'b0;
            for (int k = 0; k < LETTERS; k++) begin
                r_used[k] <= 1'b0;
            end
        end else begin
            if (place_en) begin
                r_used[place_v] <= 1'b1;
                r_fill_count    <= r_fill_count + 5'd1;
            end
            if (i_ctl.accept && (in_cmd == CMD_KEY_DONE)) begin
                r_fill_idx <= '0;
            end else if (i_ctl.fill) begin
                r_fill_idx <= r_fill_idx + 5'd1;
            end
            if (i_ctl.accept) begin
                if (msg_take && !r_pend_valid) begin
                    r_pend_valid <= 1'b1;
                end else if ((msg_pair && !dup) || end_pair) begin
                    r_pend_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && msg_take && !r_pend_valid) begin
            r_pend_letter <= msg_v;
        end
        if (i_ctl.accept && (msg_pair || end_pair)) begin
            r_pair_a <= r_pend_letter;
            r_pair_b <= pair_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_en) begin
            mem_pos[place_v]     <= r_fill_count;
            mem_sq[r_fill_count] <= place_v;
        end
        r_pos_a <= mem_pos[r_pair_a];
        r_pos_b <= mem_pos[r_pair_b];
    end

    always_comb begin
        r1 = pos_row(r_pos_a);
        c1 = pos_col(r_pos_a);
        r2 = pos_row(r_pos_b);
        c2 = pos_col(r_pos_b);
        if (r1 == r2) begin
            addr_a = cell_addr(r1, wrap_next(c1));
            addr_b = cell_addr(r2, wrap_next(c2));
        end else if (c1 == c2) begin
            addr_a = cell_addr(wrap_next(r1), c1);
            addr_b = cell_addr(wrap_next(r2), c2);
        end else begin
            addr_a = cell_addr(r1, c2);
            addr_b = cell_addr(r2, c1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_a <= mem_sq[addr_a];
        r_cell_b <= mem_sq[addr_b];
    end

    assign o_cipher_letter = i_ctl.second ? r_cell_b : r_cell_a;
    assign o_last          = i_ctl.second;

    `PFE_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill_count <= 5'(CELLS), "square overfilled")
    `PFE_ASSERT(a_idx_bound, i_clk, i_rst_n, r_fill_idx <= 5'(LETTERS), "fill index overrun")
    `PFE_ASSERT(a_pend_hold, i_clk, i_rst_n, !i_ctl.accept |=> $stable(r_pend_valid), "pending changed without accept")

endmodule

`default_nettype wire

[sv/pfe_ctrl.sv]
// ----------------------------------------------------------------------------
// Playfair controller
// Sequences accept, key fill sweep, memory lookups and the two output words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfair_encrypt_defines.svh"

module pfe_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    input  pfe_pkg::t_sts   i_sts,
    output pfe_pkg::t_ctl   o_ctl
);
    import pfe_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.key_done) begin
                        n_state = S_FILL;
                    end else if (i_sts.pair) begin
                        n_state = S_POS;
                    end
                end
            end
            S_FILL: begin
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            S_POS:  n_state = S_CELL;
            S_CELL: n_state = S_OUT0;
            S_OUT0: begin
                if (i_out_ready) n_state = S_OUT1;
            end
            S_OUT1: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = (r_state == S_OUT0) || (r_state == S_OUT1);
        o_ctl.accept = (r_state == S_IDLE) && i_in_valid;
        o_ctl.fill   = (r_state == S_FILL);
        o_ctl.second = (r_state == S_OUT1);
    end

    `PFE_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input and output open together")
    `PFE_ASSERT(a_out1_order, i_clk, i_rst_n, (r_state == S_OUT1) |-> ($past(r_state) == S_OUT0 || $past(r_state) == S_OUT1), "second word without first")
    `PFE_ASSERT(a_fill_entry, i_clk, i_rst_n, (o_in_ready && i_in_valid && i_sts.key_done) |=> (r_state == S_FILL), "key done did not start fill")

endmodule

`default_nettype wire

[sv/playfair_encrypt.sv]
// ----------------------------------------------------------------------------
// Playfair encryption
// Top level: controller and datapath joined to the input and output channels.
// ----------------------------------------------------------------------------
// Timing: a key letter word is finished at its accept. A key done word is
// accepted, then sweeps over all 26 letters, one letter per cycle through
// the single write port of the square and position memories. A message or
// end word that completes a pair goes through the accept, a registered
// read of the two letter positions, a registered read of the two square
// cells, then the two cipher letter words, each held while the output
// stalls. Other message and end words are finished at the accept. A new
// word is taken only once the previous one has finished.
`default_nettype none

module playfair_encrypt (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfe_in_if.sink     i_msg,
    pfe_out_if.source  o_ct
);
    import pfe_pkg::*;

    t_ctl ctl;
    t_sts sts;

    pfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_msg.valid),
        .o_in_ready  (i_msg.ready),
        .o_out_valid (o_ct.valid),
        .i_out_ready (o_ct.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    pfe_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_in_cmd        (i_msg.cmd),
        .i_in_letter     (i_msg.letter),
        .o_cipher_letter (o_ct.cipher_letter),
        .o_last          (o_ct.last)
    );

endmodule

`default_nettype wire

[tb/playfair_encrypt_checker.sv]
// ----------------------------------------------------------------------------
// Playfair encryption checker
// Watches the command and cipher channels, keeps its own copy of the letter
// square and the pending pair letter, predicts the cipher words for every
// accepted command word and compares them in order with what the block sends.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_encrypt_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    pfe_in_if     i_msg,
    pfe_out_if    o_ct,
    output int    o_error_count,
    output int    o_cipher_pending
);
    import pfe_pkg::*;

    typedef struct {
        logic [LETTER_W-1:0] cipher_letter;
        logic                last;
    } t_cipher_word;

    logic [LETTER_W-1:0] square   [CELLS];
    logic [LETTER_W-1:0] cell_of  [LETTERS];
    logic                placed   [LETTERS];
    logic [LETTER_W-1:0] fill_count;
    logic [LETTER_W-1:0] held_letter;
    logic                held_valid;

    t_cipher_word        cipher_q[$];
    int                  err_cnt = 0;

    t_cipher_word        got;
    t_cipher_word        want;
    logic [LETTER_W-1:0] in_letter;
    t_cmd                in_cmd;

    initial begin
        o_error_count    = 0;
        o_cipher_pending = 0;
    end

    function automatic void place_letter(input logic [LETTER_W-1:0] v);
        if (v >= LETTERS || v == LETTER_J || placed[v] || fill_count >= CELLS)
            return;
        square[fill_count] = v;
        cell_of[v]         = fill_count;
        placed[v]          = 1'b1;
        fill_count         = fill_count + 1'b1;
    endfunction

    // row rule: step right, column rule: step down, else swap columns
    function automatic void encrypt_pair(input logic [LETTER_W-1:0] a,
                                         input logic [LETTER_W-1:0] b);
        int r1, c1, r2, c2;
        t_cipher_word w;
        r1 = cell_of[a] / SIDE;
        c1 = cell_of[a] % SIDE;
        r2 = cell_of[b] / SIDE;
        c2 = cell_of[b] % SIDE;
        if (r1 == r2) begin
            c1 = (c1 + 1) % SIDE;
            c2 = (c2 + 1) % SIDE;
        end else if (c1 == c2) begin
            r1 = (r1 + 1) % SIDE;
            r2 = (r2 + 1) % SIDE;
        end else begin
            int t;
            t  = c1;
            c1 = c2;
            c2 = t;
        end
        w.cipher_letter = square[r1 * SIDE + c1];
        w.last          = 1'b0;
        cipher_q.push_back(w);
        w.cipher_letter = square[r2 * SIDE + c2];
        w.last          = 1'b1;
        cipher_q.push_back(w);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++)
                square[k] = '0;
            for (int k = 0; k < LETTERS; k++) begin
                cell_of[k] = '0;
                placed[k]  = 1'b0;
            end
            fill_count  = '0;
            held_letter = '0;
            held_valid  = 1'b0;
            cipher_q.delete();
        end else begin
            if (o_ct.valid && o_ct.ready) begin
                got.cipher_letter = o_ct.cipher_letter;
                got.last          = o_ct.last;
                if (cipher_q.size() == 0) begin
                    $error("cipher_letter: no word expected, got %0d", got.cipher_letter);
                    err_cnt++;
                end else begin
                    want = cipher_q.pop_front();
                    if (got.cipher_letter !== want.cipher_letter) begin
                        $error("cipher_letter: expected %0d, got %0d",
                               want.cipher_letter, got.cipher_letter);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        err_cnt++;
                    end
                end
            end

            if (i_msg.valid && i_msg.ready) begin
                in_cmd    = t_cmd'(i_msg.cmd);
                in_letter = i_msg.letter;
                case (in_cmd)
                    CMD_KEY: begin
                        place_letter(in_letter);
                    end
                    CMD_KEY_DONE: begin
                        for (int k = 0; k < LETTERS; k++)
                            place_letter(LETTER_W'(k));
                    end
                    CMD_MSG: begin
                        if (fill_count >= CELLS && in_letter < LETTERS) begin
                            if (in_letter == LETTER_J)
                                in_letter = LETTER_I;
                            if (!held_valid) begin
                                held_letter = in_letter;
                                held_valid  = 1'b1;
                            end else if (in_letter == held_letter) begin
                                // doubled letter: emit it with a filler, keep the new one
                                encrypt_pair(held_letter,
                                             (in_letter == LETTER_X) ? LETTER_Q : LETTER_X);
                            end else begin
                                held_valid = 1'b0;
                                encrypt_pair(held_letter, in_letter);
                            end
                        end
                    end
                    CMD_END: begin
                        if (fill_count >= CELLS && held_valid) begin
                            held_valid = 1'b0;
                            encrypt_pair(held_letter, LETTER_X);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_error_count    <= err_cnt;
        o_cipher_pending <= cipher_q.size();
    end

endmodule

`default_nettype wire

[tb/playfair_encrypt_tb.sv]
// ----------------------------------------------------------------------------
// Playfair encryption testbench
// Builds a key square with repeats, J and out-of-range letters, then streams
// directed and random messages (doubled letters, J, odd endings, noise) with
// random gaps and output stalls. The checker beside the block does the
// prediction; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_encrypt_tb;
    import pfe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int          MSG_WORDS   = 950;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          calm = 1'b0;
    int          error_count;
    int          cipher_pending;
    int unsigned cycles = 0;

    pfe_in_if  msg_if();
    pfe_out_if ct_if();

    playfair_encrypt dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if),
        .o_ct    (ct_if)
    );

    playfair_encrypt_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_msg            (msg_if),
        .o_ct             (ct_if),
        .o_error_count    (error_count),
        .o_cipher_pending (cipher_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        ct_if.ready <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("playfair_encrypt_tb: errors");
            $finish;
        end
    end

    function automatic logic [LETTER_W-1:0] code_of(input byte ch);
        return LETTER_W'(ch - 8'd65);
    endfunction

    // hold the word until the block takes it, with an occasional gap first
    task automatic send_word(input t_cmd c, input logic [LETTER_W-1:0] l);
        int gap;
        if (!calm && $urandom_range(99) < 9) begin
            gap = $urandom_range(1, 4);
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_if.valid  <= 1'b1;
        msg_if.cmd    <= c;
        msg_if.letter <= l;
        do @(posedge i_clk); while (!msg_if.ready);
    endtask

    task automatic drain_cipher();
        do @(posedge i_clk); while (cipher_pending != 0);
    endtask

    initial begin
        int                  count;
        int                  pick;
        logic [LETTER_W-1:0] prev;
        logic [LETTER_W-1:0] l;

        msg_if.valid  <= 1'b0;
        msg_if.cmd    <= CMD_KEY;
        msg_if.letter <= '0;
        i_rst_n       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // message words before the square is complete are dropped
        send_word(CMD_MSG, code_of("A"));
        send_word(CMD_END, LETTER_W'($urandom));

        send_word(CMD_KEY, code_of("P"));
        send_word(CMD_KEY, code_of("A"));
        send_word(CMD_KEY, code_of("Y"));
        send_word(CMD_KEY, LETTER_J);
        send_word(CMD_KEY, code_of("A"));
        send_word(CMD_KEY, 5'd31);
        send_word(CMD_KEY, code_of("Z"));
        repeat (2) send_word(CMD_KEY, LETTER_W'($urandom));
        send_word(CMD_KEY_DONE, LETTER_W'($urandom));
        send_word(CMD_KEY_DONE, '0);
        send_word(CMD_KEY, code_of("B"));

        send_word(CMD_MSG, code_of("P"));
        send_word(CMD_MSG, code_of("A"));
        send_word(CMD_MSG, code_of("E"));
        send_word(CMD_MSG, code_of("E"));
        send_word(CMD_MSG, LETTER_J);
        send_word(CMD_MSG, LETTER_X);
        send_word(CMD_MSG, LETTER_X);
        send_word(CMD_END, '0);
        send_word(CMD_END, '0);
        send_word(CMD_MSG, 5'd31);
        send_word(CMD_MSG, code_of("Z"));
        send_word(CMD_END, 5'd31);
        msg_if.valid <= 1'b0;
        drain_cipher();

        count = 0;
        prev  = LETTER_X;
        while (count < MSG_WORDS) begin
            calm = (count >= 300 && count < 450);
            if (count == 600)
                drain_cipher();
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_word(t_cmd'($urandom_range(0, 1)), LETTER_W'($urandom));
            end else if (pick < 8) begin
                send_word(CMD_MSG, LETTER_W'($urandom_range(LETTERS, 31)));
            end else begin
                if (pick < 18) begin
                    send_word(CMD_END, LETTER_W'($urandom));
                end else if (pick < 32) begin
                    send_word(CMD_MSG, prev);
                end else if (pick < 36) begin
                    send_word(CMD_MSG, $urandom_range(0, 1) ? LETTER_J : LETTER_I);
                end else if (pick < 40) begin
                    prev = LETTER_X;
                    send_word(CMD_MSG, LETTER_X);
                end else begin
                    l    = LETTER_W'($urandom_range(0, LETTERS - 1));
                    prev = l;
                    send_word(CMD_MSG, l);
                end
            end
            count++;
        end
        calm = 1'b0;
        msg_if.valid <= 1'b0;

        drain_cipher();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && cipher_pending == 0)
            $display("playfair_encrypt_tb: clean");
        else
            $display("playfair_encrypt_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
